### rtl/pctd_pkg.sv
// Package with the sequencer state type of the trial-division prime counter.
package pctd_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_CHECK  = 3'd1,
    S_DIV    = 3'd2,
    S_TEST   = 3'd3,
    S_FINISH = 3'd4
  } state_e;

  // First odd candidate divisor and its square.
  localparam int unsigned FirstDivisor = 3;
  localparam int unsigned FirstSquare  = 9;

endpackage

### rtl/pctd_if.sv
// Valid/ready channel interfaces for the input and result requests.
interface pctd_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface pctd_out_if #(
  parameter int unsigned COUNT_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic                   is_prime;
  logic [COUNT_WIDTH-1:0] prime_count;
  logic                   last_out;

  modport source (output valid, is_prime, prime_count, last_out, input ready);
  modport sink   (input valid, is_prime, prime_count, last_out, output ready);
endinterface

### rtl/prime_counter_trial_division_core.sv
// Prime counter: trial division by odd candidates on one shared remainder unit.
//
//   channel  | dir | payload                          | handshake
//   ---------+-----+----------------------------------+-----------
//   in_i     | in  | value, last                      | valid/ready
//   res_o    | out | is_prime, prime_count, last_out  | valid/ready
//
// Negative, zero, one and even values go from idle straight to the finish state.
// An odd value n >= 3 is tried against odd divisors d = 3, 5, ... while d*d <= n,
// up to about sqrt(n)/2 of them: each candidate is one square compare,
// VALUE_WIDTH steps of the bit-serial remainder unit and one test.
// The input is ready only in the idle state; one request is worked at a time.
// A result waits in the output register while the next request is taken; a
// stalled result holds the sequencer in its final state. Reset clears the count.
module prime_counter_trial_division_core #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pctd_in_if.sink    in_i,
  pctd_out_if.source res_o
);
  import pctd_pkg::*;

  localparam int unsigned SqW  = VALUE_WIDTH + 2;
  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  state_e                  state_q, state_d;
  logic                    out_valid_q, out_valid_d;
  logic [COUNT_WIDTH-1:0]  total_q, total_d;

  logic [VALUE_WIDTH-1:0]  n_q, n_d;
  logic [VALUE_WIDTH-1:0]  d_q, d_d;
  logic [SqW-1:0]          sq_q, sq_d;
  logic [VALUE_WIDTH-1:0]  rem_q, rem_d;
  logic [VALUE_WIDTH-1:0]  ns_q, ns_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    prime_q, prime_d;
  logic                    last_q, last_d;
  logic                    res_prime_q, res_prime_d;
  logic [COUNT_WIDTH-1:0]  res_count_q, res_count_d;
  logic                    res_last_q, res_last_d;

  logic [VALUE_WIDTH:0]    trial;
  logic [VALUE_WIDTH-1:0]  diff;
  logic                    fits;
  logic [VALUE_WIDTH-1:0]  in_value;
  logic [COUNT_WIDTH-1:0]  total_inc;

  // Shared remainder step: shift in the next dividend bit, subtract if it fits.
  // When it fits the difference is below the divisor, so the low bits suffice.
  assign trial    = {rem_q, ns_q[VALUE_WIDTH-1]};
  assign diff     = trial[VALUE_WIDTH-1:0] - d_q;
  assign fits     = (trial >= {1'b0, d_q});
  assign in_value = in_i.value;

  // Saturating count including the current request.
  assign total_inc = (prime_q && (total_q != '1)) ? total_q + COUNT_WIDTH'(1) : total_q;

  // Sequencer: next state, datapath loads and handshakes.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    total_d     = total_q;
    n_d         = n_q;
    d_d         = d_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    ns_d        = ns_q;
    cnt_d       = cnt_q;
    prime_d     = prime_q;
    last_d      = last_q;
    res_prime_d = res_prime_q;
    res_count_d = res_count_q;
    res_last_d  = res_last_q;
    in_i.ready  = 1'b0;

    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          n_d    = in_value;
          last_d = in_i.last;
          d_d    = VALUE_WIDTH'(FirstDivisor);
          sq_d   = SqW'(FirstSquare);
          if (in_value[VALUE_WIDTH-1] || !in_value[0] || (in_value < VALUE_WIDTH'(2))) begin
            // Negative, even, zero or one: only the value two is prime.
            prime_d = (in_value == VALUE_WIDTH'(2));
            state_d = S_FINISH;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sq_q > {2'b00, n_q}) begin
          // No divisor up to the square root was found.
          prime_d = 1'b1;
          state_d = S_FINISH;
        end else begin
          rem_d   = '0;
          ns_d    = n_q;
          cnt_d   = CntW'(VALUE_WIDTH - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = fits ? diff : trial[VALUE_WIDTH-1:0];
        ns_d  = {ns_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (rem_q == '0) begin
          prime_d = 1'b0;
          state_d = S_FINISH;
        end else begin
          // Next odd candidate; (d + 2)^2 = d^2 + 4d + 4.
          d_d     = d_q + VALUE_WIDTH'(2);
          sq_d    = sq_q + {d_q, 2'b00} + SqW'(4);
          state_d = S_CHECK;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          res_prime_d = prime_q;
          res_count_d = total_inc;
          res_last_d  = last_q;
          total_d     = last_q ? '0 : total_inc;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    d_q         <= d_d;
    sq_q        <= sq_d;
    rem_q       <= rem_d;
    ns_q        <= ns_d;
    cnt_q       <= cnt_d;
    prime_q     <= prime_d;
    last_q      <= last_d;
    res_prime_q <= res_prime_d;
    res_count_q <= res_count_d;
    res_last_q  <= res_last_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.is_prime    = res_prime_q;
  assign res_o.prime_count = res_count_q;
  assign res_o.last_out    = res_last_q;

endmodule

### rtl/pctd_checker.sv
// Port-level checks of the prime counter and their bind to the top level.
module pctd_checker #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic                   is_prime_i,
  input logic [COUNT_WIDTH-1:0] prime_count_i,
  input logic                   last_out_i
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(is_prime_i) && $stable(prime_count_i) && $stable(last_out_i)))
    else $error("stalled result changed");

  // After a request is taken the input is not ready in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after a request");

  // A prime result always carries a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && is_prime_i) |-> (prime_count_i != '0))
    else $error("prime result with zero count");

endmodule

bind prime_counter_trial_division_core pctd_checker #(
  .COUNT_WIDTH(COUNT_WIDTH)
) u_pctd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .is_prime_i   (res_o.is_prime),
  .prime_count_i(res_o.prime_count),
  .last_out_i   (res_o.last_out)
);
